@@ rtl/weighted_centered_moving_average_core_assert.svh @@
// assertion macros shared by the checker of the moving average core
`ifndef WEIGHTED_CENTERED_MOVING_AVERAGE_CORE_ASSERT_SVH
`define WEIGHTED_CENTERED_MOVING_AVERAGE_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define WCMA_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define WCMA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ rtl/wcma_pkg.sv @@
// shared types and constants of the moving average core
package wcma_pkg;

    // op field codes
    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // fixed field widths
    localparam int HW_BITS  = 4;
    localparam int IDX_BITS = 5;
    localparam logic [HW_BITS-1:0] HW_RESET = 4'd1;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MAC,
        S_DRAIN,
        S_DIV_START,
        S_DIV,
        S_EMIT
    } t_state;

    // flags that travel with one tap through the read and multiply stages
    typedef struct packed {
        logic valid;
        logic keep;
    } t_tap_flags;

endpackage

@@ rtl/wcma_mem.sv @@
// sample window and tap weight memories with registered read ports
module wcma_mem import wcma_pkg::*; #(
    parameter int WIN         = 31,
    parameter int SAMPLE_BITS = 16,
    parameter int WEIGHT_BITS = 16,
    parameter int AW          = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_win_we,
    input  logic [AW-1:0]                 i_win_waddr,
    input  logic signed [SAMPLE_BITS-1:0] i_win_wdata,
    input  logic                          i_wgt_we,
    input  logic [AW-1:0]                 i_wgt_waddr,
    input  logic [WEIGHT_BITS-1:0]        i_wgt_wdata,
    input  t_tap_flags                    i_tap,
    input  logic [AW-1:0]                 i_win_raddr,
    input  logic [AW-1:0]                 i_wgt_raddr,
    output t_tap_flags                    o_tap,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic [WEIGHT_BITS-1:0]        o_weight
);

    logic signed [SAMPLE_BITS-1:0] r_win [WIN];
    logic [WEIGHT_BITS-1:0]        r_wgt [WIN];
    logic [WIN-1:0]                r_wvalid;
    logic signed [SAMPLE_BITS-1:0] r_rd_sample;
    logic [WEIGHT_BITS-1:0]        r_rd_wgt;
    logic                          r_rd_wv;
    t_tap_flags                    r_tap;

    // sample window, circular, one write and one read a cycle
    always_ff @(posedge i_clk) begin
        if (i_win_we) begin
            r_win[i_win_waddr] <= i_win_wdata;
        end
        r_rd_sample <= r_win[i_win_raddr];
    end

    // tap weights, one write and one read a cycle
    always_ff @(posedge i_clk) begin
        if (i_wgt_we) begin
            r_wgt[i_wgt_waddr] <= i_wgt_wdata;
        end
        r_rd_wgt <= r_wgt[i_wgt_raddr];
    end

    // written marks, an unwritten weight reads as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
        end else if (i_wgt_we) begin
            r_wvalid[i_wgt_waddr] <= 1'b1;
        end
    end

    // read flags line up with the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= '0;
        end else begin
            r_tap <= i_tap;
        end
        r_rd_wv <= r_wvalid[i_wgt_raddr];
    end

    assign o_tap    = r_tap;
    assign o_sample = r_rd_sample;
    assign o_weight = r_rd_wv ? r_rd_wgt : WEIGHT_BITS'(1);

endmodule

@@ rtl/wcma_mac.sv @@
// shared multiply-accumulate unit for the weighted sum and the weight sum
module wcma_mac import wcma_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int WEIGHT_BITS = 16,
    parameter int ACC_W       = 38,
    parameter int DEN_W       = 21
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  t_tap_flags                    i_tap,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [WEIGHT_BITS-1:0]        i_weight,
    output logic signed [ACC_W-1:0]       o_acc,
    output logic [DEN_W-1:0]              o_den,
    output logic                          o_busy
);

    localparam int PROD_W = SAMPLE_BITS + WEIGHT_BITS + 1;

    logic signed [PROD_W-1:0]   r_prod;
    logic [WEIGHT_BITS-1:0]     r_p_wgt;
    t_tap_flags                 r_p_tap;
    logic signed [ACC_W-1:0]    r_acc;
    logic [DEN_W-1:0]           r_den;
    logic signed [PROD_W-1:0]   prod;

    // signed sample times unsigned weight
    assign prod = PROD_W'(i_sample) * $signed({1'b0, i_weight});

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_tap <= '0;
        end else begin
            r_p_tap <= i_tap;
        end
        r_prod  <= prod;
        r_p_wgt <= i_weight;
    end

    // accumulate stage, taps outside the stream are skipped
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_acc <= '0;
            r_den <= '0;
        end else if (r_p_tap.valid && r_p_tap.keep) begin
            r_acc <= r_acc + ACC_W'(r_prod);
            r_den <= r_den + DEN_W'(r_p_wgt);
        end
    end

    assign o_acc  = r_acc;
    assign o_den  = r_den;
    assign o_busy = i_tap.valid | r_p_tap.valid;

endmodule

@@ rtl/wcma_div.sv @@
// restoring divider, one quotient bit a cycle
module wcma_div #(
    parameter int NUM_W = 39,
    parameter int DIV_W = 22
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DIV_W-1:0] r_den;
    logic [DIV_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;

    // trial subtract of the divisor from the shifted remainder
    assign shifted = {r_rem, r_num[NUM_W-1]};
    assign diff    = shifted - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, quotient bits shift in where numerator bits leave
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!diff[DIV_W]) begin
                r_rem <= diff[DIV_W-1:0];
                r_num <= {r_num[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DIV_W-1:0];
                r_num <= {r_num[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

@@ rtl/weighted_centered_moving_average_core.sv @@
// Centered weighted moving average with edge renormalization. A weight item
// (op 0) writes one tap weight. A sample item (op 1) then runs, for each
// result it releases, a check for the result, 2*half_width+1 taps on the
// single multiply-accumulate unit (one tap a cycle), a drain of its read and
// multiply stages, a start of the restoring divider, the divider itself, one
// quotient bit a cycle, with NUM_W = SAMPLE_BITS+WEIGHT_BITS+clog2(WIN)+2 bits,
// and a hand-off of the result to the output register, held back while a held
// result is stalled. A result whose used weights sum to zero skips the divider
// start and the divider. The input is stalled from the accepted sample until
// its last result has been handed to the output register; the output register
// lets the next item in while a result waits. At most half_width+1 results
// leave for one sample, and up to MAX_HALF+1 on the first sample after
// half_width was lowered in the middle of a stream.
module weighted_centered_moving_average_core import wcma_pkg::*; #(
    parameter int MAX_HALF    = 15,
    parameter int SAMPLE_BITS = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_op,
    input  logic [IDX_BITS-1:0]           i_weight_index,
    input  logic [WEIGHT_BITS-1:0]        i_weight_value,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_last_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_smoothed,
    output logic                          o_divide_error,
    output logic                          o_last_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [HW_BITS-1:0]            i_cfg_data
);

    localparam int WIN   = 2 * MAX_HALF + 1;
    localparam int AW    = $clog2(WIN);
    localparam int CW    = $clog2(WIN + 1);
    localparam int GW    = CW + 2;
    localparam int KW    = HW_BITS + 1;
    localparam int PW    = HW_BITS + CW;
    localparam int ACC_W = SAMPLE_BITS + WEIGHT_BITS + AW + 1;
    localparam int DEN_W = WEIGHT_BITS + AW;
    localparam int NUM_W = ACC_W + 1;
    localparam int DIV_W = DEN_W + 1;
    localparam logic [NUM_W-1:0] Q_MAX = NUM_W'((64'(1) << (SAMPLE_BITS - 1)) - 64'(1));

    t_state                        r_state;
    t_state                        n_state;
    logic [HW_BITS-1:0]            r_hw;
    logic [AW-1:0]                 r_wptr;
    logic [AW-1:0]                 n_wptr;
    logic [CW-1:0]                 r_seen;
    logic [CW-1:0]                 r_given;
    logic                          r_last;
    logic [CW-1:0]                 r_age;
    logic                          r_pend_one;
    logic [KW-1:0]                 r_k;
    logic                          r_neg;
    logic [ACC_W-1:0]              r_mag;
    logic signed [SAMPLE_BITS-1:0] r_res;
    logic                          r_err;
    logic                          r_o_valid;
    logic signed [SAMPLE_BITS-1:0] r_o_smoothed;
    logic                          r_o_err;
    logic                          r_o_last;

    logic                          in_fire;
    logic                          wgt_we;
    logic [CW-1:0]                 pending;
    logic                          res_done;
    logic                          k_last;
    logic [GW-1:0]                 g_full;
    logic [CW-1:0]                 g_pos;
    logic                          g_keep;
    logic [CW:0]                   win_off;
    logic [AW-1:0]                 win_raddr;
    logic                          out_free;
    logic                          emit_fire;
    t_tap_flags                    tap_issue;
    t_tap_flags                    tap_rd;
    logic                          mac_clear;
    logic                          div_start;
    logic signed [SAMPLE_BITS-1:0] rd_sample;
    logic [WEIGHT_BITS-1:0]        rd_weight;
    logic signed [ACC_W-1:0]       acc;
    logic [DEN_W-1:0]              den;
    logic                          mac_busy;
    logic                          div_done;
    logic [NUM_W-1:0]              quot;
    logic [NUM_W-1:0]              div_num;
    logic [DIV_W-1:0]              div_den;
    logic signed [SAMPLE_BITS-1:0] sat_val;

    // handshakes
    assign in_fire   = i_valid && !o_stall;
    assign wgt_we    = in_fire && (i_op == OP_WEIGHT) && (32'(i_weight_index) < WIN);
    assign out_free  = !r_o_valid || !i_stall;
    assign emit_fire = (r_state == S_EMIT) && out_free;

    // pending results and the stop test
    assign pending  = r_seen - r_given;
    assign res_done = (pending == '0) || (!r_last && (PW'(pending) <= PW'(r_hw)));
    assign k_last   = (r_k == {r_hw, 1'b0});

    // window position of the current tap and its memory address
    assign g_full  = GW'(r_age) + GW'(r_hw) - GW'(r_k);
    assign g_pos   = g_full[CW-1:0];
    assign g_keep  = !g_full[GW-1] && (g_full < GW'(r_seen));
    assign win_off = ((CW + 1)'(r_wptr) < (CW + 1)'(g_pos))
                   ? (CW + 1)'(r_wptr) + (CW + 1)'(WIN) - (CW + 1)'(g_pos)
                   : (CW + 1)'(r_wptr) - (CW + 1)'(g_pos);
    assign win_raddr = AW'(win_off);
    assign n_wptr    = (r_wptr == AW'(WIN - 1)) ? '0 : r_wptr + AW'(1);

    // divider operands, rounding to nearest by (2*mag + den) / (2*den)
    assign div_num = {r_mag, 1'b0} + NUM_W'(den);
    assign div_den = {den, 1'b0};

    // saturate the rounded magnitude and apply the sign
    always_comb begin
        if (r_neg) begin
            if (quot > Q_MAX + NUM_W'(1)) begin
                sat_val = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
            end else begin
                sat_val = SAMPLE_BITS'(0) - quot[SAMPLE_BITS-1:0];
            end
        end else begin
            if (quot > Q_MAX) begin
                sat_val = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
            end else begin
                sat_val = quot[SAMPLE_BITS-1:0];
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (i_op == OP_SAMPLE)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = res_done ? S_IDLE : S_MAC;
            end
            S_MAC: begin
                if (k_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!mac_busy) begin
                    n_state = (den == '0) ? S_EMIT : S_DIV_START;
                end
            end
            S_DIV_START: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_stall        = (r_state != S_IDLE);
        o_cfg_ready    = (r_state == S_IDLE);
        tap_issue.valid = (r_state == S_MAC);
        tap_issue.keep  = (r_state == S_MAC) && g_keep;
        mac_clear      = (r_state == S_CHECK);
        div_start      = (r_state == S_DIV_START);
    end

    // state register and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hw    <= HW_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (32'(i_cfg_data) > MAX_HALF) begin
                    r_hw <= HW_BITS'(MAX_HALF);
                end else begin
                    r_hw <= i_cfg_data;
                end
            end
        end
    end

    // stream counters and write pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_seen  <= '0;
            r_given <= '0;
        end else begin
            if (in_fire && (i_op == OP_SAMPLE)) begin
                r_wptr <= n_wptr;
                if (r_seen != CW'(WIN)) begin
                    r_seen <= r_seen + CW'(1);
                end else if (r_given != '0) begin
                    r_given <= r_given - CW'(1);
                end
            end else if ((r_state == S_CHECK) && res_done && r_last) begin
                r_seen  <= '0;
                r_given <= '0;
            end else if (emit_fire) begin
                r_given <= r_given + CW'(1);
            end
        end
    end

    // per-result working registers
    always_ff @(posedge i_clk) begin
        if (in_fire && (i_op == OP_SAMPLE)) begin
            r_last <= i_last_in;
        end
        if (r_state == S_CHECK) begin
            r_age      <= pending - CW'(1);
            r_pend_one <= (pending == CW'(1));
            r_k        <= '0;
        end else if (r_state == S_MAC) begin
            r_k <= r_k + KW'(1);
        end
        if ((r_state == S_DRAIN) && !mac_busy) begin
            r_neg <= acc[ACC_W-1];
            r_mag <= acc[ACC_W-1] ? ACC_W'(0) - ACC_W'(acc) : ACC_W'(acc);
            r_res <= '0;
            r_err <= 1'b1;
        end else if ((r_state == S_DIV) && div_done) begin
            r_res <= sat_val;
            r_err <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit_fire) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
        if (emit_fire) begin
            r_o_smoothed <= r_res;
            r_o_err      <= r_err;
            r_o_last     <= r_last && r_pend_one;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_smoothed     = r_o_smoothed;
    assign o_divide_error = r_o_err;
    assign o_last_out     = r_o_last;

    wcma_mem #(
        .WIN         (WIN),
        .SAMPLE_BITS (SAMPLE_BITS),
        .WEIGHT_BITS (WEIGHT_BITS),
        .AW          (AW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win_we    (in_fire && (i_op == OP_SAMPLE)),
        .i_win_waddr (n_wptr),
        .i_win_wdata (i_sample),
        .i_wgt_we    (wgt_we),
        .i_wgt_waddr (AW'(i_weight_index)),
        .i_wgt_wdata (i_weight_value),
        .i_tap       (tap_issue),
        .i_win_raddr (win_raddr),
        .i_wgt_raddr (AW'(r_k)),
        .o_tap       (tap_rd),
        .o_sample    (rd_sample),
        .o_weight    (rd_weight)
    );

    wcma_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WEIGHT_BITS (WEIGHT_BITS),
        .ACC_W       (ACC_W),
        .DEN_W       (DEN_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (mac_clear),
        .i_tap    (tap_rd),
        .i_sample (rd_sample),
        .i_weight (rd_weight),
        .o_acc    (acc),
        .o_den    (den),
        .o_busy   (mac_busy)
    );

    wcma_div #(
        .NUM_W (NUM_W),
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

endmodule

@@ rtl/wcma_checker.sv @@
// port-level checker of the moving average core and its bind
`include "weighted_centered_moving_average_core_assert.svh"

module wcma_checker import wcma_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int WEIGHT_BITS = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          i_op,
    input logic [IDX_BITS-1:0]           i_weight_index,
    input logic [WEIGHT_BITS-1:0]        i_weight_value,
    input logic signed [SAMPLE_BITS-1:0] i_sample,
    input logic                          i_last_in,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic signed [SAMPLE_BITS-1:0] o_smoothed,
    input logic                          o_divide_error,
    input logic                          o_last_out,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [HW_BITS-1:0]            i_cfg_data
);

    // a stalled result item holds
    `WCMA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_smoothed) && $stable(o_divide_error) && $stable(o_last_out))

    // a zero weight sum gives a zero mean
    `WCMA_ASSERT_IMPLY(a_err_zero, i_clk, i_rst_n, o_valid && o_divide_error, o_smoothed == '0)

    // a weight item leaves the block ready for the next item
    `WCMA_ASSERT_NEXT(a_wgt_ready, i_clk, i_rst_n, i_valid && !o_stall && (i_op == OP_WEIGHT), !o_stall)

    // an accepted sample item stalls the input and the configuration port
    `WCMA_ASSERT_NEXT(a_smp_busy, i_clk, i_rst_n, i_valid && !o_stall && (i_op == OP_SAMPLE), o_stall && !o_cfg_ready)

endmodule

bind weighted_centered_moving_average_core wcma_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
) u_wcma_checker (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the weighted centered moving average core
module tb_top import wcma_pkg::*;;

    localparam int MAX_HALF      = 15;
    localparam int SAMPLE_BITS   = 16;
    localparam int WEIGHT_BITS   = 16;
    localparam int TAPS          = 2 * MAX_HALF + 1;
    localparam int MAX_RESULTS   = 16;
    localparam int SMP_MAX       = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SMP_MIN       = -SMP_MAX - 1;
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 400;
    localparam int LIMIT_CYCLES  = 2500000;
    localparam int PHASE_ITEMS   = 45;
    localparam int NUM_PHASES    = 10;

    // one input item as offered to the core
    typedef struct {
        logic                          op;
        logic [IDX_BITS-1:0]           widx;
        logic [WEIGHT_BITS-1:0]        wval;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic                          last;
    } t_avg_item;

    // one smoothed result
    typedef struct {
        logic signed [SAMPLE_BITS-1:0] smoothed;
        logic                          div_err;
        logic                          last;
    } t_avg_result;

    // directed stimulus row, optionally with a hand-written result
    typedef struct {
        t_avg_item   item;
        logic        typed;
        t_avg_result want;
    } t_dir_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic                          i_op;
    logic [IDX_BITS-1:0]           i_weight_index;
    logic [WEIGHT_BITS-1:0]        i_weight_value;
    logic signed [SAMPLE_BITS-1:0] i_sample;
    logic                          i_last_in;
    logic                          o_valid;
    logic                          i_stall;
    logic signed [SAMPLE_BITS-1:0] o_smoothed;
    logic                          o_divide_error;
    logic                          o_last_out;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [HW_BITS-1:0]            i_cfg_data;

    // smoothing state mirrored by the testbench
    logic signed [SAMPLE_BITS-1:0] win_smp [TAPS];
    logic [WEIGHT_BITS-1:0]        tap_wgt [TAPS];
    int                            n_seen;
    int                            n_given;
    int                            half_w;
    t_avg_result                   step_res [$];
    t_avg_result                   smooth_q [$];
    t_dir_row                      dir_rows [$];

    int n_errors    = 0;
    int cyc_count   = 0;
    int stream_left = 0;
    int burst_left  = 0;
    bit hold_req    = 1'b0;

    weighted_centered_moving_average_core #(
        .MAX_HALF    (MAX_HALF),
        .SAMPLE_BITS (SAMPLE_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_weight_index (i_weight_index),
        .i_weight_value (i_weight_value),
        .i_sample       (i_sample),
        .i_last_in      (i_last_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_smoothed     (o_smoothed),
        .o_divide_error (o_divide_error),
        .o_last_out     (o_last_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // weighted mean over the taps that exist for the pending sample of this age
    function automatic t_avg_result weighted_mean(input int age);
        t_avg_result r;
        longint      acc;
        longint      den;
        longint      mag;
        longint      q;
        int          g;
        int          tap;
        acc = 0;
        den = 0;
        for (g = age - half_w; g <= age + half_w; g++) begin
            tap = age - g + half_w;
            if (g >= 0 && g < n_seen && g < TAPS && tap < TAPS) begin
                acc += longint'(win_smp[g]) * longint'(tap_wgt[tap]);
                den += longint'(tap_wgt[tap]);
            end
        end
        r.last = 1'b0;
        if (den == 0) begin
            r.smoothed = '0;
            r.div_err  = 1'b1;
            return r;
        end
        r.div_err = 1'b0;
        mag = (acc < 0) ? -acc : acc;
        // round half away from zero, then saturate
        q = (2 * mag + den) / (2 * den);
        if (acc < 0) begin
            r.smoothed = (q > SMP_MAX + 1) ? SAMPLE_BITS'(SMP_MIN) : SAMPLE_BITS'(-q);
        end else begin
            r.smoothed = (q > SMP_MAX) ? SAMPLE_BITS'(SMP_MAX) : SAMPLE_BITS'(q);
        end
        return r;
    endfunction

    // update the mirrored state for one item, results land in step_res
    function automatic void predict_item(input t_avg_item it);
        t_avg_result r;
        int          i;
        int          pending;
        step_res.delete();
        if (it.op == OP_WEIGHT) begin
            if (it.widx < TAPS) tap_wgt[it.widx] = it.wval;
            return;
        end
        for (i = TAPS - 1; i > 0; i--) win_smp[i] = win_smp[i - 1];
        win_smp[0] = it.smp;
        // sample count saturates, then the given count slides down instead
        if (n_seen < TAPS) n_seen++;
        else if (n_given > 0) n_given--;
        pending = (n_seen > n_given) ? n_seen - n_given : 0;
        while (step_res.size() < MAX_RESULTS && pending > 0 && (it.last || pending > half_w)) begin
            r = weighted_mean(pending - 1);
            r.last = it.last && (pending == 1);
            step_res.push_back(r);
            n_given++;
            pending = n_seen - n_given;
        end
        if (it.last) begin
            n_seen  = 0;
            n_given = 0;
        end
    endfunction

    // directed table entry
    function automatic void add_row(input logic op, input int idx, input int wval, input int smp,
                                    input logic last, input logic typed, input int want_val,
                                    input logic want_err, input logic want_last);
        t_dir_row row;
        row.item.op        = op;
        row.item.widx      = IDX_BITS'(idx);
        row.item.wval      = WEIGHT_BITS'(wval);
        row.item.smp       = SAMPLE_BITS'(smp);
        row.item.last      = last;
        row.typed          = typed;
        row.want.smoothed  = SAMPLE_BITS'(want_val);
        row.want.div_err   = want_err;
        row.want.last      = want_last;
        dir_rows.push_back(row);
    endfunction

    // random item, samples grouped into streams of random length
    function automatic t_avg_item rand_item();
        t_avg_item it;
        it.widx = IDX_BITS'($urandom_range(0, 31));
        case ($urandom_range(0, 7))
            0:       it.wval = '0;
            1:       it.wval = '1;
            default: it.wval = WEIGHT_BITS'($urandom);
        endcase
        if ($urandom_range(0, 15) == 0) begin
            it.smp = $urandom_range(0, 1) ? SAMPLE_BITS'(SMP_MAX) : SAMPLE_BITS'(SMP_MIN);
        end else begin
            it.smp = SAMPLE_BITS'($urandom);
        end
        if ($urandom_range(0, 7) == 0) begin
            it.op   = OP_WEIGHT;
            it.last = 1'($urandom_range(0, 1));
        end else begin
            it.op = OP_SAMPLE;
            if (stream_left == 0) begin
                stream_left = ($urandom_range(0, 5) == 0) ? $urandom_range(32, 48)
                                                          : $urandom_range(1, 12);
            end
            stream_left--;
            it.last = (stream_left == 0);
        end
        return it;
    endfunction

    // present one item, wait for acceptance, queue what it should produce
    task automatic offer_item(input t_avg_item it, input logic typed, input t_avg_result want);
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_op           <= it.op;
        i_weight_index <= it.widx;
        i_weight_value <= it.wval;
        i_sample       <= it.smp;
        i_last_in      <= it.last;
        do @(posedge i_clk); while (o_stall);
        predict_item(it);
        if (typed) begin
            smooth_q.push_back(want);
        end else begin
            foreach (step_res[k]) smooth_q.push_back(step_res[k]);
        end
    endtask

    // sender gap, input valid dropped for a time set by n
    task automatic pause_input(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // stop sending, let every result come out and the core settle
    task automatic wait_results_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (smooth_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // half_width write, only with the core idle
    task automatic write_half_width(input logic [HW_BITS-1:0] hw);
        wait_results_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= hw;
        do @(posedge i_clk); while (!o_cfg_ready);
        half_w = (hw > MAX_HALF) ? MAX_HALF : int'(hw);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random items in bursts, or back to back
    task automatic run_phase(input int n_items, input bit back_to_back);
        t_avg_item   it;
        t_avg_result no_want;
        int          i;
        no_want.smoothed = '0;
        no_want.div_err  = 1'b0;
        no_want.last     = 1'b0;
        for (i = 0; i < n_items; i++) begin
            it = rand_item();
            if (!back_to_back) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 8));
                end
                burst_left--;
            end
            offer_item(it, 1'b0, no_want);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_avg_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (smooth_q.size() == 0) begin
                $display("%0t: result with none expected: smoothed %0d divide_error %0b last %0b",
                         $time, o_smoothed, o_divide_error, o_last_out);
                n_errors++;
            end else begin
                exp_r = smooth_q.pop_front();
                if (o_smoothed !== exp_r.smoothed) begin
                    $display("%0t: smoothed expected %0d actual %0d",
                             $time, exp_r.smoothed, o_smoothed);
                    n_errors++;
                end
                if (o_divide_error !== exp_r.div_err) begin
                    $display("%0t: divide_error expected %0b actual %0b",
                             $time, exp_r.div_err, o_divide_error);
                    n_errors++;
                end
                if (o_last_out !== exp_r.last) begin
                    $display("%0t: last_out expected %0b actual %0b",
                             $time, exp_r.last, o_last_out);
                    n_errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cyc_count++;
        if (cyc_count > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results outstanding", $time, smooth_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold-off on request
    initial begin
        int mode;
        int tick;
        i_stall = 1'b0;
        mode    = 0;
        tick    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else begin
                if (tick % 64 == 0) mode = $urandom_range(0, 3);
                tick++;
                case (mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // main stimulus
    initial begin
        logic [HW_BITS-1:0] plan [NUM_PHASES];
        int                 i;
        int                 p;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_op           = OP_WEIGHT;
        i_weight_index = '0;
        i_weight_value = '0;
        i_sample       = '0;
        i_last_in      = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        for (i = 0; i < TAPS; i++) begin
            win_smp[i] = '0;
            tap_wgt[i] = WEIGHT_BITS'(1);
        end
        n_seen  = 0;
        n_given = 0;
        half_w  = int'(HW_RESET);

        // directed table, half_width 1 and unit weights after reset
        // single-sample streams at the sample extremes
        add_row(OP_SAMPLE, 0, 0, SMP_MAX, 1'b1, 1'b1, SMP_MAX, 1'b0, 1'b1);
        add_row(OP_SAMPLE, 0, 0, SMP_MIN, 1'b1, 1'b1, SMP_MIN, 1'b0, 1'b1);
        // truncated window at stream start and end
        add_row(OP_SAMPLE, 0, 0, 100, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(OP_SAMPLE, 0, 0, 200, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(OP_SAMPLE, 0, 0, 301, 1'b1, 1'b0, 0, 1'b0, 1'b0);
        // weight extremes, ignored index, zero center tap
        add_row(OP_WEIGHT, 0, 65535, 0, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(OP_WEIGHT, 2, 65535, 0, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(OP_WEIGHT, 31, 1234, -1, 1'b1, 1'b0, 0, 1'b0, 1'b0);
        add_row(OP_WEIGHT, 30, 16'hAAAA, 0, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(OP_WEIGHT, 1, 0, 0, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        // lone sample on a zero weight gives a divide error
        add_row(OP_SAMPLE, 0, 0, 5555, 1'b1, 1'b1, 0, 1'b1, 1'b1);
        // large negative accumulation
        add_row(OP_SAMPLE, 0, 0, SMP_MIN, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(OP_SAMPLE, 0, 0, SMP_MIN, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(OP_SAMPLE, 0, 0, SMP_MIN, 1'b1, 1'b0, 0, 1'b0, 1'b0);
        // large positive accumulation, all taps at full weight
        add_row(OP_WEIGHT, 1, 65535, 0, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(OP_SAMPLE, 0, 0, SMP_MAX, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(OP_SAMPLE, 0, 0, SMP_MAX, 1'b1, 1'b0, 0, 1'b0, 1'b0);
        // all used weights zero
        add_row(OP_WEIGHT, 0, 0, 0, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(OP_WEIGHT, 1, 0, 0, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(OP_WEIGHT, 2, 0, 0, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(OP_SAMPLE, 0, 0, 7, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(OP_SAMPLE, 0, 0, 8, 1'b1, 1'b0, 0, 1'b0, 1'b0);
        // back to unit weights
        add_row(OP_WEIGHT, 0, 1, 0, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(OP_WEIGHT, 1, 1, 0, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(OP_WEIGHT, 2, 1, 0, 1'b0, 1'b0, 0, 1'b0, 1'b0);

        // half_width per phase, extremes included; streams run on across changes
        plan = '{4'd0, 4'd15, 4'd3, 4'd1, 4'd7, 4'd15, 4'd0, 4'd5, 4'd2, 4'd11};
        plan[7] = HW_BITS'($urandom_range(0, 15));

        // reset
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) offer_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);

        for (p = 0; p < NUM_PHASES; p++) begin
            write_half_width(plan[p]);
            if (p == 2) begin
                // receiver holds off while items keep coming, core backs up
                hold_req = 1'b1;
                run_phase(PHASE_ITEMS, 1'b1);
            end else begin
                run_phase(PHASE_ITEMS, 1'b0);
            end
        end

        wait_results_drained();
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
